// ===== rtl/tfb_pkg.sv =====
// Shared constants, types and the CRC step function for the telemetry frame builder.
package tfb_pkg;

   // Channel count limits
   localparam int MAX_CHANNELS = 8;
   localparam int CHANNEL_COUNT_DEFAULT = 8;

   // Frame constants
   localparam logic [7:0] SYNC_HEAD = 8'h5A;
   localparam logic [7:0] FILL_BYTE = 8'hFF;
   localparam logic [7:0] SYNC_TAIL = 8'hA5;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [7:0] MASK_RESET = 8'd27;

   // Byte counts of each frame section
   localparam int HEAD_BYTES = 5;
   localparam int CHAN_BYTES = 3;
   localparam int TAIL_BYTES = 4;
   localparam int IDX_W = 3;

   // Byte source select codes
   localparam int SEL_W = 4;
   localparam logic [SEL_W-1:0] SEL_SYNC_HEAD = 4'd0;
   localparam logic [SEL_W-1:0] SEL_LENGTH    = 4'd1;
   localparam logic [SEL_W-1:0] SEL_FILL      = 4'd2;
   localparam logic [SEL_W-1:0] SEL_CHAN      = 4'd3;
   localparam logic [SEL_W-1:0] SEL_VAL_HI    = 4'd4;
   localparam logic [SEL_W-1:0] SEL_VAL_LO    = 4'd5;
   localparam logic [SEL_W-1:0] SEL_CRC_HI    = 4'd6;
   localparam logic [SEL_W-1:0] SEL_CRC_LO    = 4'd7;
   localparam logic [SEL_W-1:0] SEL_SYNC_TAIL = 4'd8;

   // Commands from controller to datapath
   typedef struct packed {
      logic             start;
      logic             emit;
      logic             crc_en;
      logic             next_chan;
      logic             last;
      logic [SEL_W-1:0] sel;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
      logic pend_any;
      logic pend_more;
   } sts_type;

   // Fold one byte into a CRC-16/XMODEM remainder
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/tfb_if.sv =====
// Handshake channel interfaces for snapshot requests and frame byte responses.
interface tfb_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] value_0;
   logic [15:0] value_1;
   logic [15:0] value_2;
   logic [15:0] value_3;
   logic [15:0] value_4;
   logic [15:0] value_5;
   logic [15:0] value_6;
   logic [15:0] value_7;

   modport source (output valid, value_0, value_1, value_2, value_3,
                   value_4, value_5, value_6, value_7, input ready);
   modport sink (input valid, value_0, value_1, value_2, value_3,
                 value_4, value_5, value_6, value_7, output ready);
endinterface

interface tfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_byte;

   modport source (output valid, tx_byte, last_byte, input ready);
   modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

// ===== rtl/telemetry_frame_builder_crc16.sv =====
// Top level: telemetry frame builder with CRC-16/XMODEM over the channel triplets.
// The sequencer enters its head state once the snapshot beat is taken, and the first frame
// byte is then loaded into the output register. A frame of 9 + 3*N bytes (N enabled
// channels) leaves from the output register at one byte per cycle while the receiver is
// ready; the next snapshot can be taken in the cycle after the last byte is loaded.
// Reset: enable mask returns to 0x1B, the sequencer goes idle and the output is empty.
module telemetry_frame_builder_crc16 #(
   parameter int CHANNEL_COUNT = tfb_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tfb_req_if.sink     req_bus,
   tfb_rsp_if.source   rsp_bus,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   tfb_pkg::cmd_type cmd;
   tfb_pkg::sts_type sts;
   logic [15:0]      all_vals [tfb_pkg::MAX_CHANNELS];
   logic [15:0]      vals [CHANNEL_COUNT];

   // Gather channel samples
   assign all_vals[0] = req_bus.value_0;
   assign all_vals[1] = req_bus.value_1;
   assign all_vals[2] = req_bus.value_2;
   assign all_vals[3] = req_bus.value_3;
   assign all_vals[4] = req_bus.value_4;
   assign all_vals[5] = req_bus.value_5;
   assign all_vals[6] = req_bus.value_6;
   assign all_vals[7] = req_bus.value_7;

   for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_vals
      assign vals[g] = all_vals[g];
   end

   tfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tfb_dpath #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .values        (vals),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_tx_byte   (rsp_bus.tx_byte),
      .rsp_last_byte (rsp_bus.last_byte)
   );

`ifndef SYNTHESIS
   // A byte is loaded only when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("frame byte loaded over a waiting byte");

   // A new snapshot is never taken while a frame is being sent
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !req_bus.ready)
      else $error("snapshot port ready during a frame");

   // Only emitted bytes enter the CRC
   a_crc_with_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.crc_en |-> cmd.emit)
      else $error("CRC advanced without a byte");
`endif

endmodule

// ===== rtl/tfb_ctrl.sv =====
// Frame sequencer: walks head, channel triplets and tail, one byte per beat.
module tfb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tfb_pkg::sts_type  sts,
   output tfb_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_HEAD = 2'd1;
   localparam logic [1:0] ST_CHAN = 2'd2;
   localparam logic [1:0] ST_TAIL = 2'd3;

   localparam logic [tfb_pkg::IDX_W-1:0] HEAD_END =
      tfb_pkg::IDX_W'(tfb_pkg::HEAD_BYTES - 1);
   localparam logic [tfb_pkg::IDX_W-1:0] CHAN_END =
      tfb_pkg::IDX_W'(tfb_pkg::CHAN_BYTES - 1);
   localparam logic [tfb_pkg::IDX_W-1:0] TAIL_END =
      tfb_pkg::IDX_W'(tfb_pkg::TAIL_BYTES - 1);

   logic [1:0]                state_ff, state_in;
   logic [tfb_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                      adv;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      req_ready = 1'b0;
      adv       = sts.out_free;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_HEAD;
               idx_in    = '0;
            end
         end
         ST_HEAD: begin
            cmd.emit = adv;
            if (idx_ff < tfb_pkg::IDX_W'(2)) begin
               cmd.sel = tfb_pkg::SEL_SYNC_HEAD;
            end else if (idx_ff == tfb_pkg::IDX_W'(2)) begin
               cmd.sel = tfb_pkg::SEL_LENGTH;
            end else begin
               cmd.sel = tfb_pkg::SEL_FILL;
            end
            if (adv) begin
               if (idx_ff == HEAD_END) begin
                  idx_in   = '0;
                  state_in = sts.pend_any ? ST_CHAN : ST_TAIL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_CHAN: begin
            cmd.emit   = adv;
            cmd.crc_en = adv;
            if (idx_ff == '0) begin
               cmd.sel = tfb_pkg::SEL_CHAN;
            end else if (idx_ff == tfb_pkg::IDX_W'(1)) begin
               cmd.sel = tfb_pkg::SEL_VAL_HI;
            end else begin
               cmd.sel = tfb_pkg::SEL_VAL_LO;
            end
            if (adv) begin
               if (idx_ff == CHAN_END) begin
                  cmd.next_chan = 1'b1;
                  idx_in        = '0;
                  state_in      = sts.pend_more ? ST_CHAN : ST_TAIL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_TAIL: begin
            cmd.emit = adv;
            if (idx_ff == '0) begin
               cmd.sel = tfb_pkg::SEL_CRC_HI;
            end else if (idx_ff == tfb_pkg::IDX_W'(1)) begin
               cmd.sel = tfb_pkg::SEL_CRC_LO;
            end else begin
               cmd.sel = tfb_pkg::SEL_SYNC_TAIL;
            end
            cmd.last = (idx_ff == TAIL_END);
            if (adv) begin
               if (idx_ff == TAIL_END) begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            idx_in   = '0;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/tfb_dpath.sv =====
// Snapshot store, enable mask, CRC accumulator and output byte register.
module tfb_dpath #(
   parameter int CHANNEL_COUNT = tfb_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      values [CHANNEL_COUNT],
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  tfb_pkg::cmd_type cmd,
   output tfb_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last_byte
);

   localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int LEN_W = $clog2(CHANNEL_COUNT + 1);

   logic [7:0]               mask_ff, mask_in;
   logic [15:0]              snap_ff [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0] remain_ff, remain_in;
   logic [LEN_W-1:0]         length_ff, length_in;
   logic [15:0]              crc_ff, crc_in;
   logic                     valid_ff, valid_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     last_ff, last_in;
   logic [CH_W-1:0]          chan_idx;
   logic [15:0]              chan_val;
   logic [7:0]               sel_byte;

   // Find the lowest channel still pending
   always_comb begin
      chan_idx = '0;
      for (int k = CHANNEL_COUNT - 1; k >= 0; k--) begin
         if (remain_ff[k]) begin
            chan_idx = CH_W'(k);
         end
      end
   end

   assign chan_val = snap_ff[chan_idx];

   // Pick the frame byte
   always_comb begin
      case (cmd.sel)
         tfb_pkg::SEL_SYNC_HEAD: sel_byte = tfb_pkg::SYNC_HEAD;
         tfb_pkg::SEL_LENGTH:    sel_byte = 8'(length_ff);
         tfb_pkg::SEL_FILL:      sel_byte = tfb_pkg::FILL_BYTE;
         tfb_pkg::SEL_CHAN:      sel_byte = 8'(chan_idx);
         tfb_pkg::SEL_VAL_HI:    sel_byte = chan_val[15:8];
         tfb_pkg::SEL_VAL_LO:    sel_byte = chan_val[7:0];
         tfb_pkg::SEL_CRC_HI:    sel_byte = crc_ff[15:8];
         tfb_pkg::SEL_CRC_LO:    sel_byte = crc_ff[7:0];
         tfb_pkg::SEL_SYNC_TAIL: sel_byte = tfb_pkg::SYNC_TAIL;
         default:                sel_byte = tfb_pkg::FILL_BYTE;
      endcase
   end

   // Next values
   always_comb begin
      mask_in   = csr_wr_en ? csr_wr_data : mask_ff;
      remain_in = remain_ff;
      length_in = length_ff;
      crc_in    = crc_ff;
      if (cmd.start) begin
         remain_in = mask_ff[CHANNEL_COUNT-1:0];
         length_in = LEN_W'($countones(mask_ff[CHANNEL_COUNT-1:0]));
         crc_in    = '0;
      end else begin
         if (cmd.next_chan) begin
            remain_in = remain_ff & (remain_ff - 1'b1);
         end
         if (cmd.crc_en) begin
            crc_in = tfb_pkg::crc_byte(crc_ff, sel_byte);
         end
      end
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         last_in  = cmd.last;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= tfb_pkg::MASK_RESET;
         remain_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         mask_ff   <= mask_in;
         remain_ff <= remain_in;
         valid_ff  <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      length_ff <= length_in;
      crc_ff    <= crc_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      if (cmd.start) begin
         snap_ff <= values;
      end
   end

   assign sts.out_free  = !valid_ff || rsp_ready;
   assign sts.pend_any  = |remain_ff;
   assign sts.pend_more = |(remain_ff & (remain_ff - 1'b1));

   assign rsp_valid     = valid_ff;
   assign rsp_tx_byte   = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

// ===== tb/telemetry_frame_builder_crc16_test.sv =====
// Self-checking testbench for the telemetry frame builder: driver, predictor, byte checker.
`timescale 1ns / 1ps

module telemetry_frame_builder_crc16_test;

   localparam int N_CHAN       = tfb_pkg::CHANNEL_COUNT_DEFAULT;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_AT_BEAT = 2500;
   localparam int HOLD_CYCLES  = 500;
   localparam int SETTLE       = 12;

   typedef logic [7:0][15:0] snapshot_type;

   typedef struct {
      snapshot_type values;
      int unsigned  gap;
      bit           drain_first;
   } pending_snapshot_type;

   typedef struct {
      logic [7:0] tx_byte;
      logic       last_byte;
   } frame_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'h00;

   tfb_req_if req_ch ();
   tfb_rsp_if rsp_ch ();

   telemetry_frame_builder_crc16 #(.CHANNEL_COUNT(N_CHAN)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pending_snapshot_type snapshot_queue[$];
   frame_byte_type       frame_bytes_due[$];
   logic [7:0]           enable_mask = tfb_pkg::MASK_RESET;
   int unsigned          snapshots_queued = 0;
   int unsigned          snapshots_taken = 0;
   int unsigned          mismatches = 0;
   int unsigned          send_idle = 0;
   bit                   send_gaps_on = 1'b0;
   bit                   recv_gaps_on = 1'b0;

   // Free-running clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Hold every block input at a known value until the processes take over
   initial begin
      req_ch.valid   = 1'b0;
      req_ch.value_0 = 16'h0000;
      req_ch.value_1 = 16'h0000;
      req_ch.value_2 = 16'h0000;
      req_ch.value_3 = 16'h0000;
      req_ch.value_4 = 16'h0000;
      req_ch.value_5 = 16'h0000;
      req_ch.value_6 = 16'h0000;
      req_ch.value_7 = 16'h0000;
      rsp_ch.ready   = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch: %s got %0h want %0h (beat due %0d)", what, got, want,
               frame_bytes_due.size());
   endtask

   // One CRC-16/XMODEM step, fed a bit at a time from the top of the byte
   function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r  = {r[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
      end
      return r;
   endfunction

   function automatic void due_byte(input logic [7:0] b, input logic fin);
      frame_byte_type fbyte;
      fbyte.tx_byte   = b;
      fbyte.last_byte = fin;
      frame_bytes_due.push_back(fbyte);
   endfunction

   // Work out the whole frame for one snapshot under the current mask
   task automatic predict_frame(input snapshot_type snap);
      logic [15:0] crc;
      logic [7:0]  count;
      logic [7:0]  hi;
      logic [7:0]  lo;
      crc   = 16'h0000;
      count = 8'd0;
      for (int ch = 0; ch < N_CHAN; ch++) begin
         if (enable_mask[ch]) begin
            count++;
         end
      end
      due_byte(tfb_pkg::SYNC_HEAD, 1'b0);
      due_byte(tfb_pkg::SYNC_HEAD, 1'b0);
      due_byte(count, 1'b0);
      due_byte(tfb_pkg::FILL_BYTE, 1'b0);
      due_byte(tfb_pkg::FILL_BYTE, 1'b0);
      for (int ch = 0; ch < N_CHAN; ch++) begin
         if (enable_mask[ch]) begin
            hi = snap[ch][15:8];
            lo = snap[ch][7:0];
            due_byte(8'(ch), 1'b0);
            due_byte(hi, 1'b0);
            due_byte(lo, 1'b0);
            crc = crc16_fold(crc, 8'(ch));
            crc = crc16_fold(crc, hi);
            crc = crc16_fold(crc, lo);
         end
      end
      due_byte(crc[15:8], 1'b0);
      due_byte(crc[7:0], 1'b0);
      due_byte(tfb_pkg::SYNC_TAIL, 1'b0);
      due_byte(tfb_pkg::SYNC_TAIL, 1'b1);
   endtask

   // Driver: predict each accepted snapshot, then offer the next after its gap
   always @(posedge clock) begin : drive
      pending_snapshot_type head;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_idle    <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_frame({req_ch.value_7, req_ch.value_6, req_ch.value_5, req_ch.value_4,
                           req_ch.value_3, req_ch.value_2, req_ch.value_1, req_ch.value_0});
            snapshots_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (snapshot_queue.size() != 0 && send_idle >= snapshot_queue[0].gap &&
                !(snapshot_queue[0].drain_first && frame_bytes_due.size() != 0)) begin
               head = snapshot_queue.pop_front();
               req_ch.valid   <= 1'b1;
               req_ch.value_0 <= head.values[0];
               req_ch.value_1 <= head.values[1];
               req_ch.value_2 <= head.values[2];
               req_ch.value_3 <= head.values[3];
               req_ch.value_4 <= head.values[4];
               req_ch.value_5 <= head.values[5];
               req_ch.value_6 <= head.values[6];
               req_ch.value_7 <= head.values[7];
               send_idle      <= 0;
            end else begin
               req_ch.valid <= 1'b0;
               send_idle    <= send_idle + 1;
            end
         end
      end
   end

   // Receiver ready: per-beat random wait, plus one long hold-off mid-run
   always @(posedge clock) begin : accept
      int unsigned wait_left;
      int unsigned hold_left;
      int unsigned beats_seen;
      bit          hold_done;
      int unsigned w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         wait_left  = 0;
         hold_left  = 0;
         beats_seen = 0;
         hold_done  = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_seen++;
         end
         if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= (hold_left == 0);
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            w = recv_gaps_on ? $urandom_range(0, 9) : 0;
            wait_left = w;
            rsp_ch.ready <= (w == 0);
         end else if (wait_left != 0) begin
            wait_left--;
            rsp_ch.ready <= (wait_left == 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Monitor: compare each frame beat with the oldest one due
   always @(posedge clock) begin : check
      frame_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (frame_bytes_due.size() == 0) begin
            report_mismatch("unexpected beat, tx_byte", rsp_ch.tx_byte, 0);
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_ch.tx_byte !== want.tx_byte) begin
               report_mismatch("tx_byte", rsp_ch.tx_byte, want.tx_byte);
            end
            if (rsp_ch.last_byte !== want.last_byte) begin
               report_mismatch("last_byte", rsp_ch.last_byte, want.last_byte);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin : watchdog
      int unsigned cycles;
      if (reset) begin
         cycles = 0;
      end else begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still due", cycles,
                     frame_bytes_due.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic queue_snapshot(input snapshot_type v, input bit drain_first);
      pending_snapshot_type p;
      p.values      = v;
      p.gap         = send_gaps_on ? $urandom_range(0, 9) : 0;
      p.drain_first = drain_first;
      snapshot_queue.push_back(p);
      snapshots_queued++;
   endtask

   // Wait until every queued snapshot is taken and its frame has left
   task automatic drain_phase();
      while (snapshots_taken != snapshots_queued || frame_bytes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_mask(input logic [7:0] m);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      enable_mask = m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) begin
         return 16'h0000;
      end else if (r == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom());
   endfunction

   // Stimulus: directed frames, then random phases over several masks
   initial begin : stimulus
      snapshot_type v;
      logic [7:0]   m;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset mask
      queue_snapshot({8{16'h0000}}, 1'b0);
      queue_snapshot({8{16'hFFFF}}, 1'b0);
      for (int i = 0; i < 8; i++) begin
         v[i] = 16'h0001 << (2 * i);
      end
      queue_snapshot(v, 1'b0);
      queue_snapshot({8{16'h8001}}, 1'b0);
      drain_phase();

      // No channel enabled: bare header, zero CRC, tail
      write_mask(8'h00);
      queue_snapshot({8{16'hFFFF}}, 1'b0);
      queue_snapshot({8{16'h1234}}, 1'b0);
      drain_phase();

      // Every channel
      write_mask(8'hFF);
      queue_snapshot({8{16'h0000}}, 1'b0);
      queue_snapshot({8{16'hFFFF}}, 1'b0);
      queue_snapshot({8{16'h00FF}}, 1'b0);
      queue_snapshot({8{16'hFF00}}, 1'b0);
      for (int i = 0; i < 8; i++) begin
         v[i] = (i % 2) ? 16'hA5A5 : 16'h5A5A;
      end
      queue_snapshot(v, 1'b0);
      drain_phase();

      // Single channels at either end, then alternate channels
      write_mask(8'h80);
      queue_snapshot({8{16'hFFFF}}, 1'b0);
      queue_snapshot({8{16'h0000}}, 1'b0);
      drain_phase();
      write_mask(8'h01);
      queue_snapshot({8{16'hFFFF}}, 1'b0);
      queue_snapshot({8{16'h0000}}, 1'b0);
      drain_phase();
      write_mask(8'hAA);
      queue_snapshot({8{16'hC3C3}}, 1'b0);
      queue_snapshot({8{16'h3C3C}}, 1'b0);
      drain_phase();

      // Random phases; every third one runs without idling on either side
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            2:       m = 8'h00;
            5:       m = 8'hFF;
            8:       m = 8'h01;
            10:      m = 8'h80;
            default: m = 8'($urandom());
         endcase
         write_mask(m);
         send_gaps_on = (ph % 3 != 0);
         recv_gaps_on = (ph % 3 != 0) && (ph != 4);
         for (int k = 0; k < 35; k++) begin
            for (int i = 0; i < 8; i++) begin
               v[i] = pick_value();
            end
            queue_snapshot(v, k == 17);
         end
         drain_phase();
      end

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== telemetry_frame_builder_crc16.f =====
rtl/tfb_pkg.sv
rtl/tfb_if.sv
rtl/tfb_ctrl.sv
rtl/tfb_dpath.sv
rtl/telemetry_frame_builder_crc16.sv
tb/telemetry_frame_builder_crc16_test.sv
